// ===== rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg: shared types for the bitmap frame allocator
// Request and result words, status codes, and the microcode word layout
// that passes between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int FRAME_W = 12;   // frame number field
  localparam int TP_W    = 13;   // total_pages register
  localparam int FRAME_FIELD_LIMIT = 4096;
  localparam logic [TP_W-1:0] TP_RESET = 13'h1000;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } bfa_func_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_MAPPED   = 2'd1,
    ST_NO_FRAME = 2'd2,
    ST_NOTHING  = 2'd3
  } bfa_status_t;

  typedef struct packed {
    bfa_func_t          func;
    logic [FRAME_W-1:0] current_frame;
    logic               kernel_page;
    logic               rw_page;
  } bfa_in_t;

  typedef struct packed {
    bfa_status_t        status;
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               writable;
    logic               user_mode;
  } bfa_out_t;

  // Microcode step addresses
  typedef enum logic [2:0] {
    S_CLEAR    = 3'd0,
    S_IDLE     = 3'd1,
    S_DISPATCH = 3'd2,
    S_PRIME    = 3'd3,
    S_SCAN     = 3'd4,
    S_MODIFY   = 3'd5,
    S_FAIL     = 3'd6,
    S_REPLY    = 3'd7
  } bfa_step_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NONE       = 3'd0,
    C_NO_START   = 3'd1,
    C_MORE_WORDS = 3'd2,
    C_QUICK      = 3'd3,
    C_PAST       = 3'd4,
    C_HIT        = 3'd5
  } bfa_cond_t;

  // Result register update
  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_QUICK = 2'd1,
    RES_DONE  = 2'd2,
    RES_FAIL  = 2'd3
  } bfa_res_t;

  // Datapath controls issued each step
  typedef struct packed {
    logic     idle;      // accept a request, rewind the scan counters
    logic     clr_wr;    // write a zero word at the scan pointer
    logic     rd;        // read the bitmap word at the scan pointer
    logic     wadv;      // advance the scan pointer
    logic     base_inc;  // advance the frame base by one word
    logic     mod_wr;    // write back the modified word
    logic     reply;     // present the result
    bfa_res_t res;
  } bfa_ctrl_t;

  // Status flags fed back to the sequencer
  typedef struct packed {
    logic more_words;
    logic quick;
    logic past;
    logic hit;
  } bfa_flags_t;

  typedef struct packed {
    bfa_ctrl_t ctrl;
    logic      hold_on_br;  // suppress advances when a jump is taken
    bfa_cond_t cond_a;
    bfa_step_t tgt_a;
    bfa_cond_t cond_b;
    bfa_step_t tgt_b;
    bfa_step_t nxt;
  } bfa_uword_t;

endpackage

// ===== rtl/bfa_seq.sv =====
// ----------------------------------------------------------------------------
// bfa_seq: microcode sequencer
// Step counter, control store and two-way conditional jump logic.
// ----------------------------------------------------------------------------
module bfa_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bfa_pkg::bfa_flags_t flags,
  output bfa_pkg::bfa_ctrl_t  ctrl
);
  import bfa_pkg::*;

  bfa_step_t  pc_r;
  bfa_step_t  pc_nxt;
  bfa_uword_t uw;
  logic       take_a;
  logic       take_b;

  function automatic logic cond_true(input bfa_cond_t c, input bfa_flags_t f,
                                     input logic st);
    logic r;
    unique case (c)
      C_NONE:       r = 1'b0;
      C_NO_START:   r = ~st;
      C_MORE_WORDS: r = f.more_words;
      C_QUICK:      r = f.quick;
      C_PAST:       r = f.past;
      C_HIT:        r = f.hit;
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

  // Control store
  always_comb begin
    uw = '0;
    unique case (pc_r)
      S_CLEAR: begin
        uw.ctrl.clr_wr = 1'b1;
        uw.ctrl.wadv   = 1'b1;
        uw.cond_a      = C_MORE_WORDS;
        uw.tgt_a       = S_CLEAR;
        uw.nxt         = S_IDLE;
      end
      S_IDLE: begin
        uw.ctrl.idle = 1'b1;
        uw.cond_a    = C_NO_START;
        uw.tgt_a     = S_IDLE;
        uw.nxt       = S_DISPATCH;
      end
      S_DISPATCH: begin
        uw.ctrl.res = RES_QUICK;
        uw.cond_a   = C_QUICK;
        uw.tgt_a    = S_REPLY;
        uw.nxt      = S_PRIME;
      end
      S_PRIME: begin
        uw.ctrl.rd   = 1'b1;
        uw.ctrl.wadv = 1'b1;
        uw.nxt       = S_SCAN;
      end
      S_SCAN: begin
        uw.ctrl.rd       = 1'b1;
        uw.ctrl.wadv     = 1'b1;
        uw.ctrl.base_inc = 1'b1;
        uw.hold_on_br    = 1'b1;
        uw.cond_a        = C_PAST;
        uw.tgt_a         = S_FAIL;
        uw.cond_b        = C_HIT;
        uw.tgt_b         = S_MODIFY;
        uw.nxt           = S_SCAN;
      end
      S_MODIFY: begin
        uw.ctrl.mod_wr = 1'b1;
        uw.ctrl.res    = RES_DONE;
        uw.nxt         = S_REPLY;
      end
      S_FAIL: begin
        uw.ctrl.res = RES_FAIL;
        uw.nxt      = S_REPLY;
      end
      S_REPLY: begin
        uw.ctrl.reply = 1'b1;
        uw.nxt        = S_IDLE;
      end
    endcase
  end

  // Next step: first jump wins, else fall to the listed next step
  always_comb begin
    take_a = cond_true(uw.cond_a, flags, start);
    take_b = cond_true(uw.cond_b, flags, start);
    if (take_a) begin
      pc_nxt = uw.tgt_a;
    end else if (take_b) begin
      pc_nxt = uw.tgt_b;
    end else begin
      pc_nxt = uw.nxt;
    end
  end

  // Issued controls: hold the scan pointer where a jump leaves the loop
  always_comb begin
    ctrl = uw.ctrl;
    if (uw.hold_on_br && (take_a || take_b)) begin
      ctrl.rd       = 1'b0;
      ctrl.wadv     = 1'b0;
      ctrl.base_inc = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_CLEAR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/bfa_dpath.sv =====
// ----------------------------------------------------------------------------
// bfa_dpath: bitmap store and scan datapath
// Holds the used-frame bitmap, the scan pointer and frame base, the
// total_pages register and the result word.
// ----------------------------------------------------------------------------
module bfa_dpath #(
  parameter int MAX_FRAMES = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bfa_pkg::bfa_ctrl_t      ctrl,
  output bfa_pkg::bfa_flags_t     flags,
  input  logic                    start,
  input  bfa_pkg::bfa_in_t        in_req,
  input  logic                    cfg_we,
  input  logic [bfa_pkg::TP_W-1:0] cfg_data,
  output bfa_pkg::bfa_out_t       out_res
);
  import bfa_pkg::*;

  localparam int WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW    = $clog2(WORDS + 1);
  localparam int BASEW = $clog2(WORDS * WORD_BITS + 1);
  localparam int CMPW  = (BASEW > TP_W) ? BASEW : TP_W;
  localparam int SW    = CMPW + 1;
  localparam int BW    = $clog2(WORD_BITS);
  localparam int LIM   = (MAX_FRAMES < FRAME_FIELD_LIMIT) ? MAX_FRAMES : FRAME_FIELD_LIMIT;
  localparam logic [TP_W-1:0] LIM_C = TP_W'(LIM);

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic [CW-1:0]        w_r;
  logic [BASEW-1:0]     base_r;
  logic [TP_W-1:0]      total_pages_r;
  bfa_in_t              req_r;
  bfa_out_t             res_r;
  bfa_out_t             res_nxt;

  logic [TP_W-1:0]      limit;
  logic [CMPW-1:0]      base_c;
  logic [CMPW-1:0]      rem;
  logic [WORD_BITS-1:0] free_vec;
  logic [BW-1:0]        pos;
  logic [BW-1:0]        fbit;
  logic                 is_alloc;
  logic                 in_word;
  logic                 beyond;
  logic [CW-1:0]        wm1;
  logic                 mem_we;
  logic [AW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] mod_word;
  logic [CMPW-1:0]      frame_sum;

  // Scan window: limit is the smallest of total_pages, the bitmap and the frame field
  always_comb begin
    limit    = (total_pages_r < LIM_C) ? total_pages_r : LIM_C;
    base_c   = CMPW'(base_r);
    rem      = CMPW'(limit) - base_c;
    is_alloc = (req_r.func == FN_ALLOC);
    beyond   = (int'(req_r.current_frame) >= MAX_FRAMES);
    in_word  = SW'(req_r.current_frame) < (SW'(base_c) + SW'(WORD_BITS));
    fbit     = BW'(CMPW'(req_r.current_frame) - base_c);
  end

  // Mark free bits inside the window and pick the lowest
  always_comb begin
    pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      free_vec[i] = ~rdata_r[i] & (CMPW'(i) < rem);
    end
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        pos = BW'(i);
      end
    end
  end

  // Feed status back to the sequencer
  always_comb begin
    flags.more_words = (w_r != CW'(WORDS - 1));
    flags.quick      = is_alloc ? (req_r.current_frame != '0)
                                : ((req_r.current_frame == '0) || beyond);
    flags.past       = is_alloc & (base_c >= CMPW'(limit));
    flags.hit        = is_alloc ? (|free_vec) : in_word;
  end

  // Write port: zero words on the clearing pass, else the modified word
  always_comb begin
    wm1      = w_r - CW'(1);
    mod_word = is_alloc ? (rdata_r | (WORD_BITS'(1) << pos))
                        : (rdata_r & ~(WORD_BITS'(1) << fbit));
    mem_we   = ctrl.clr_wr | ctrl.mod_wr;
    waddr    = ctrl.clr_wr ? w_r[AW-1:0] : wm1[AW-1:0];
    wdata    = ctrl.clr_wr ? '0 : mod_word;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (ctrl.rd) begin
      rdata_r <= mem[w_r[AW-1:0]];
    end
  end

  // Scan pointer, frame base and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r           <= '0;
      base_r        <= '0;
      total_pages_r <= TP_RESET;
    end else begin
      if (cfg_we) begin
        total_pages_r <= cfg_data;
      end
      if (ctrl.idle) begin
        w_r    <= '0;
        base_r <= '0;
      end else begin
        if (ctrl.wadv) begin
          w_r <= w_r + CW'(1);
        end
        if (ctrl.base_inc) begin
          base_r <= base_r + BASEW'(WORD_BITS);
        end
      end
    end
  end

  // Latch the request word on acceptance
  always_ff @(posedge clk) begin
    if (ctrl.idle && start) begin
      req_r <= in_req;
    end
  end

  // Build the result word
  always_comb begin
    frame_sum = base_c + CMPW'(pos);
    res_nxt   = res_r;
    case (ctrl.res)
      RES_NONE: begin
      end
      RES_QUICK: begin
        res_nxt = '0;
        if (is_alloc) begin
          res_nxt.status = ST_MAPPED;
          res_nxt.frame  = req_r.current_frame;
        end else begin
          res_nxt.status = (req_r.current_frame == '0) ? ST_NOTHING : ST_DONE;
        end
      end
      RES_DONE: begin
        res_nxt        = '0;
        res_nxt.status = ST_DONE;
        if (is_alloc) begin
          res_nxt.frame     = frame_sum[FRAME_W-1:0];
          res_nxt.present   = 1'b1;
          res_nxt.writable  = req_r.rw_page;
          res_nxt.user_mode = ~req_r.kernel_page;
        end
      end
      RES_FAIL: begin
        res_nxt        = '0;
        res_nxt.status = ST_NO_FRAME;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_res = res_r;

endmodule

// ===== rtl/bitmap_frame_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_unit: first-fit page frame allocator
// One used bit per frame in an on-chip bitmap; allocates the lowest free
// frame below total_pages and frees frames by number.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   request | start, busy, in_req              | in
//   result  | out_strobe, out_res              | out
//   config  | cfg_valid, cfg_ready, cfg_data   | in
//
// A request already mapped, a free of frame zero or a free beyond the
// bitmap goes from dispatch straight to the reply step, with no scan. An
// allocation or a real free primes a read, then scans the bitmap one word
// per cycle through the single memory read port, then modifies or fails and
// replies; at most MAX_FRAMES / WORD_BITS + 1 words are read, reached when an
// allocation finds no free frame (129 at the defaults). The next request is
// taken as the result shows. After reset a clearing pass zeroes the bitmap,
// one word a cycle with busy high; cfg writes are always taken.
// Each result word shows for one cycle under out_strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_unit #(
  parameter int MAX_FRAMES = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  bfa_pkg::bfa_in_t         in_req,
  output logic                     out_strobe,
  output bfa_pkg::bfa_out_t        out_res,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [bfa_pkg::TP_W-1:0] cfg_data
);
  import bfa_pkg::*;

  bfa_ctrl_t  ctrl;
  bfa_flags_t flags;
  logic       out_strobe_r;

  bfa_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .ctrl  (ctrl)
  );

  bfa_dpath #(
    .MAX_FRAMES (MAX_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .flags    (flags),
    .start    (start),
    .in_req   (in_req),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .out_res  (out_res)
  );

  // Strobe the result word for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctrl.reply;
    end
  end

  assign out_strobe = out_strobe_r;
  assign busy       = ~ctrl.idle;
  assign cfg_ready  = 1'b1;

  // One strobe per request, never back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // Even the fastest request passes the dispatch and reply steps before its strobe
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_strobe ##1 !out_strobe)
    else $error("result strobed too soon after acceptance");

  // A result is only shown once the block is free again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobed while busy");

endmodule
